### rtl/lkvc_pkg.sv
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared types and constants for the LRU key/value cache.
// ----------------------------------------------------------------------------
package lkvc_pkg;

  localparam int KEY_W  = 64;
  localparam int DATA_W = 64;
  localparam int CAP_W  = 4;

  localparam logic [CAP_W-1:0] CAP_RESET = 4'd8;

  typedef enum logic {
    FUNC_PUT = 1'b0,
    FUNC_GET = 1'b1
  } func_t;

  typedef struct packed {
    func_t              func;
    logic [KEY_W-1:0]   key;
    logic [DATA_W-1:0]  payload;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic [DATA_W-1:0]  read_data;
    logic               evicted;
  } rsp_t;

endpackage

### rtl/lru_key_value_cache_core.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache_core
// Fully associative key/value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Takes one put or get request per clock and returns one response per request,
// passing through the input register and then the response register. Keys,
// valid bits and recency ranks sit in flops and are compared against the
// request key in parallel; a rank update and a victim pick happen in that same
// pass. Payload data lives in a RAM whose registered read port forms the data
// part of the response register, so a sustained rate of one request per cycle
// holds whenever the response side does not stall. Write capacity via cfg only
// while idle (the block does not check); 0 acts as 1, above ENTRIES saturates.
// ----------------------------------------------------------------------------
module lru_key_value_cache_core #(
  parameter int ENTRIES   = 8,
  parameter int KEY_BITS  = 64,
  parameter int DATA_BITS = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  lkvc_pkg::req_t               in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output lkvc_pkg::rsp_t               out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [lkvc_pkg::CAP_W-1:0]   cfg_data
);

  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int RANK_W = IDX_W;

  // request stage
  logic                        s1_v_r;
  lkvc_pkg::req_t              req_r;

  // response stage
  logic                        out_v_r;
  logic                        hit_r;
  logic                        evict_r;
  logic                        get_hit_r;
  logic [DATA_BITS-1:0]        ram_rdata;

  // cache state
  logic [lkvc_pkg::CAP_W-1:0]  cap_r;
  logic [ENTRIES-1:0]          valid_r, valid_nxt;
  logic [KEY_BITS-1:0]         key_r  [ENTRIES];
  logic [RANK_W-1:0]           rank_r [ENTRIES];
  logic [RANK_W-1:0]           rank_nxt [ENTRIES];
  logic [CNT_W-1:0]            fill_r, fill_nxt;

  logic                        advance;
  logic                        in_acc;
  logic [CNT_W-1:0]            cap_eff;
  logic [KEY_BITS-1:0]         req_key;
  logic [ENTRIES-1:0]          match;
  logic [IDX_W-1:0]            match_idx;
  logic [RANK_W-1:0]           match_rank;
  logic                        is_hit;
  logic                        is_put;
  logic                        need_evict;
  logic [RANK_W-1:0]           lru_rank;
  logic [ENTRIES-1:0]          victim_oh;
  logic [ENTRIES-1:0]          free_vec;
  logic [ENTRIES-1:0]          free_oh;
  logic [ENTRIES-1:0]          ins_oh;
  logic [IDX_W-1:0]            ins_idx;
  logic                        do_ins;
  logic                        do_touch;

  // ---------------- handshake ----------------
  assign advance   = s1_v_r && (!out_v_r || !out_stall);
  assign in_stall  = s1_v_r && !advance;
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_acc) begin
      s1_v_r <= 1'b1;
    end else if (advance) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= lkvc_pkg::CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cap_r <= cfg_data;
    end
  end

  // ---------------- lookup ----------------
  always_comb begin
    if (cap_r == '0) begin
      cap_eff = CNT_W'(1);
    end else if (int'(cap_r) > ENTRIES) begin
      cap_eff = CNT_W'(ENTRIES);
    end else begin
      cap_eff = CNT_W'(cap_r);
    end
  end

  assign req_key = req_r.key[KEY_BITS-1:0];
  assign is_put  = (req_r.func == lkvc_pkg::FUNC_PUT);

  // valid keys are distinct, so at most one entry matches
  always_comb begin
    match_idx  = '0;
    match_rank = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = valid_r[i] && (key_r[i] == req_key);
      if (match[i]) begin
        match_idx  = match_idx | IDX_W'(i);
        match_rank = match_rank | rank_r[i];
      end
    end
  end

  assign is_hit     = |match;
  assign need_evict = (fill_r >= cap_eff);

  // valid ranks are always 0..fill-1, so the LRU entry holds rank fill-1
  assign lru_rank = RANK_W'(fill_r - CNT_W'(1));

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      victim_oh[i] = valid_r[i] && (rank_r[i] == lru_rank);
    end
  end

  assign free_vec = ~valid_r;
  assign free_oh  = free_vec & (~free_vec + ENTRIES'(1));
  assign ins_oh   = need_evict ? victim_oh : free_oh;

  always_comb begin
    ins_idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (ins_oh[i]) begin
        ins_idx = ins_idx | IDX_W'(i);
      end
    end
  end

  assign do_ins   = advance && is_put && !is_hit;
  assign do_touch = advance && is_hit;

  // ---------------- state update ----------------
  always_comb begin
    valid_nxt = valid_r;
    fill_nxt  = fill_r;
    for (int i = 0; i < ENTRIES; i++) begin
      rank_nxt[i] = rank_r[i];
    end
    if (do_touch) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (match[i]) begin
          rank_nxt[i] = '0;
        end else if (valid_r[i] && (rank_r[i] < match_rank)) begin
          rank_nxt[i] = rank_r[i] + RANK_W'(1);
        end
      end
    end
    if (do_ins) begin
      valid_nxt = valid_r | ins_oh;
      if (!need_evict) begin
        fill_nxt = fill_r + CNT_W'(1);
      end
      for (int i = 0; i < ENTRIES; i++) begin
        if (ins_oh[i]) begin
          rank_nxt[i] = '0;
        end else if (valid_r[i]) begin
          rank_nxt[i] = rank_r[i] + RANK_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      fill_r  <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_r[i] <= '0;
      end
    end else begin
      valid_r <= valid_nxt;
      fill_r  <= fill_nxt;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_r[i] <= rank_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (do_ins && ins_oh[i]) begin
        key_r[i] <= req_key;
      end
    end
  end

  // payload store: write on any put, read at the match on every pass
  lkvc_ram #(
    .WIDTH (DATA_BITS),
    .DEPTH (ENTRIES)
  ) u_data_ram (
    .clk     (clk),
    .wr_en   (advance && is_put),
    .wr_addr (is_hit ? match_idx : ins_idx),
    .wr_data (req_r.payload[DATA_BITS-1:0]),
    .rd_en   (advance),
    .rd_addr (match_idx),
    .rd_data (ram_rdata)
  );

  // ---------------- response ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      hit_r     <= is_hit;
      evict_r   <= is_put && !is_hit && need_evict;
      get_hit_r <= is_hit && !is_put;
    end
  end

  assign out_valid          = out_v_r;
  assign out_data.hit       = hit_r;
  assign out_data.evicted   = evict_r;
  assign out_data.read_data = get_hit_r ? lkvc_pkg::DATA_W'(ram_rdata) : '0;

  // ---------------- assertions ----------------
  a_match_unique: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r |-> $onehot0(match))
    else $error("more than one entry matches the request key");

  a_fill_tracks_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == int'(fill_r))
    else $error("fill count out of step with valid entries");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(fill_r) <= ENTRIES)
    else $error("fill count above entry count");

  a_advance_resp: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_v_r)
    else $error("processed request produced no response");

  a_evict_only_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && evict_r) |-> !hit_r)
    else $error("eviction flagged on a hit");

endmodule

### rtl/lkvc_ram.sv
// ----------------------------------------------------------------------------
// lkvc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lkvc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
